>>> sv/mvna_pkg.sv
package mvna_pkg;

   localparam int MaxVertices = 1024;
   localparam int IdxW = 10;
   localparam int PosW = 16;
   localparam int NormW = 16;
   localparam int SumW = 32;
   localparam int VecW = 36;
   localparam int FqDepth = 4;
   localparam int OfDepth = 2;

   localparam logic [1:0] CmdLoad = 2'd0;
   localparam logic [1:0] CmdFace = 2'd1;
   localparam logic [1:0] CmdQuery = 2'd2;

   localparam logic KindFace = 1'b0;
   localparam logic KindVertex = 1'b1;

   typedef struct packed {
      logic [1:0] cmd;
      logic [IdxW-1:0] idx_raw;
      logic [IdxW-1:0] ka;
      logic [IdxW-1:0] kb;
      logic [IdxW-1:0] kc;
      logic [IdxW-1:0] kd;
      logic quad;
      logic bad;
      logic signed [PosW-1:0] pos_x;
      logic signed [PosW-1:0] pos_y;
      logic signed [PosW-1:0] pos_z;
   } item_type;

   typedef struct packed {
      logic signed [NormW-1:0] nx;
      logic signed [NormW-1:0] ny;
      logic signed [NormW-1:0] nz;
      logic degen;
   } nres_type;

   typedef struct packed {
      logic kind;
      logic [IdxW-1:0] item_index;
      logic signed [NormW-1:0] nx;
      logic signed [NormW-1:0] ny;
      logic signed [NormW-1:0] nz;
      logic degen;
      logic bad;
   } rsp_type;

endpackage

>>> sv/mvna_front.sv
module mvna_front #(
   parameter int MAX_VERTICES = mvna_pkg::MaxVertices
) (
   input  logic clock,
   input  logic reset,
   input  logic hold,
   input  logic req_push,
   output logic req_full,
   input  logic [1:0] req_cmd,
   input  logic [mvna_pkg::IdxW-1:0] req_index_a,
   input  logic [mvna_pkg::IdxW-1:0] req_index_b,
   input  logic [mvna_pkg::IdxW-1:0] req_index_c,
   input  logic [mvna_pkg::IdxW-1:0] req_index_d,
   input  logic [2:0] req_corner_count,
   input  logic signed [mvna_pkg::PosW-1:0] req_pos_x,
   input  logic signed [mvna_pkg::PosW-1:0] req_pos_y,
   input  logic signed [mvna_pkg::PosW-1:0] req_pos_z,
   output mvna_pkg::item_type head,
   output logic head_valid,
   input  logic pop
);

   localparam int PtrW = $clog2(mvna_pkg::FqDepth);
   localparam int CntW = $clog2(mvna_pkg::FqDepth + 1);
   localparam int RecipShift = 20;
   localparam logic [31:0] ModC = 32'(MAX_VERTICES);
   localparam logic [31:0] RecipC = 32'((1 << RecipShift) / MAX_VERTICES);

   function automatic logic [mvna_pkg::IdxW-1:0] slot(input logic [mvna_pkg::IdxW-1:0] idx);
      logic [31:0] prod;
      logic [31:0] qv;
      logic [31:0] rem;
      prod = 32'(idx) * RecipC;
      qv = prod >> RecipShift;
      rem = 32'(idx) - qv * ModC;
      if (rem >= ModC) begin
         rem = rem - ModC;
      end
      return rem[mvna_pkg::IdxW-1:0];
   endfunction

   mvna_pkg::item_type q_mem [mvna_pkg::FqDepth];
   mvna_pkg::item_type new_item;
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic push_ok;
   logic pop_ok;
   logic q_full;

   assign q_full = (count_ff == CntW'(mvna_pkg::FqDepth));
   assign req_full = q_full || hold;
   assign push_ok = req_push && !req_full;
   assign head_valid = (count_ff != '0);
   assign pop_ok = pop && head_valid;
   assign head = q_mem[rd_ptr_ff];

   always_comb begin
      new_item.cmd = req_cmd;
      new_item.idx_raw = req_index_a;
      new_item.ka = slot(req_index_a);
      new_item.kb = slot(req_index_b);
      new_item.kc = slot(req_index_c);
      new_item.kd = slot(req_index_d);
      new_item.quad = (req_corner_count == 3'd4);
      new_item.bad = !(req_corner_count inside {[3'd3:3'd4]});
      new_item.pos_x = req_pos_x;
      new_item.pos_y = req_pos_y;
      new_item.pos_z = req_pos_z;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push_ok) begin
         wr_ptr_in = PtrW'(wr_ptr_ff + 1'b1);
      end
      if (pop_ok) begin
         rd_ptr_in = PtrW'(rd_ptr_ff + 1'b1);
      end
      if (push_ok && !pop_ok) begin
         count_in = CntW'(count_ff + 1'b1);
      end else if (pop_ok && !push_ok) begin
         count_in = CntW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_mem[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> sv/mvna_norm.sv
module mvna_norm (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [mvna_pkg::VecW-1:0] vx,
   input  logic signed [mvna_pkg::VecW-1:0] vy,
   input  logic signed [mvna_pkg::VecW-1:0] vz,
   output logic done,
   output mvna_pkg::nres_type res
);

   localparam int MagW = mvna_pkg::VecW;
   localparam logic [2:0] N_IDLE = 3'd0;
   localparam logic [2:0] N_SHIFT = 3'd1;
   localparam logic [2:0] N_SQ = 3'd2;
   localparam logic [2:0] N_SQRT = 3'd3;
   localparam logic [2:0] N_DSET = 3'd4;
   localparam logic [2:0] N_DIV = 3'd5;
   localparam logic [2:0] N_DONE = 3'd6;
   localparam logic [16:0] UnitQ = 17'd16384;

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [MagW-1:0] m_ff [3];
   logic [MagW-1:0] m_in [3];
   logic neg_ff [3];
   logic neg_in [3];
   logic [59:0] prod_ff, prod_in;
   logic [61:0] sq_ff, sq_in;
   logic [61:0] sqsh_ff, sqsh_in;
   logic [32:0] rem_ff, rem_in;
   logic [30:0] root_ff, root_in;
   logic [31:0] div_ff, div_in;
   logic [32:0] drem_ff [3];
   logic [32:0] drem_in [3];
   logic [16:0] dq_ff [3];
   logic [16:0] dq_in [3];
   mvna_pkg::nres_type res_ff, res_in;

   logic signed [MagW-1:0] vin [3];
   logic [MagW-1:0] any_m;
   logic [29:0] sq_op;
   logic [34:0] rem_t;
   logic [34:0] trial;
   logic [45:0] dvd;
   logic [33:0] r_t;
   logic ge;
   logic [15:0] qc [3];

   assign vin[0] = vx;
   assign vin[1] = vy;
   assign vin[2] = vz;
   assign any_m = m_ff[0] | m_ff[1] | m_ff[2];
   assign done = (state_ff == N_DONE);
   assign res = res_ff;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0: sq_op = m_ff[0][29:0];
         2'd1: sq_op = m_ff[1][29:0];
         default: sq_op = m_ff[2][29:0];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      m_in = m_ff;
      neg_in = neg_ff;
      prod_in = prod_ff;
      sq_in = sq_ff;
      sqsh_in = sqsh_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      div_in = div_ff;
      drem_in = drem_ff;
      dq_in = dq_ff;
      res_in = res_ff;
      rem_t = {rem_ff, sqsh_ff[61:60]};
      trial = {2'b00, root_ff, 2'b01};
      dvd = '0;
      r_t = '0;
      ge = 1'b0;
      for (int i = 0; i < 3; i++) begin
         qc[i] = '0;
      end
      case (state_ff)
         N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = vin[i][MagW-1];
                  m_in[i] = vin[i][MagW-1] ? MagW'(-vin[i]) : MagW'(vin[i]);
               end
               if ((vx == '0) && (vy == '0) && (vz == '0)) begin
                  res_in = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
                  state_in = N_DONE;
               end else begin
                  state_in = N_SHIFT;
               end
            end
         end
         N_SHIFT: begin
            if (|any_m[MagW-1:30]) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] >> 1;
               end
            end else if (!any_m[29]) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] << 1;
               end
            end else begin
               cnt_in = '0;
               sq_in = '0;
               state_in = N_SQ;
            end
         end
         N_SQ: begin
            prod_in = sq_op * sq_op;
            if (cnt_ff != '0) begin
               sq_in = sq_ff + 62'(prod_ff);
            end
            cnt_in = 5'(cnt_ff + 1'b1);
            if (cnt_ff == 5'd3) begin
               sqsh_in = sq_in;
               rem_in = '0;
               root_in = '0;
               cnt_in = '0;
               state_in = N_SQRT;
            end
         end
         N_SQRT: begin
            if (rem_t >= trial) begin
               rem_in = 33'(rem_t - trial);
               root_in = {root_ff[29:0], 1'b1};
            end else begin
               rem_in = rem_t[32:0];
               root_in = {root_ff[29:0], 1'b0};
            end
            sqsh_in = sqsh_ff << 2;
            cnt_in = 5'(cnt_ff + 1'b1);
            if (cnt_ff == 5'd30) begin
               state_in = N_DSET;
            end
         end
         N_DSET: begin
            div_in = {root_ff, 1'b0};
            for (int i = 0; i < 3; i++) begin
               dvd = {1'b0, m_ff[i][29:0], 15'b0} + 46'(root_ff);
               drem_in[i] = 33'(dvd[45:17]);
               dq_in[i] = dvd[16:0];
            end
            cnt_in = '0;
            state_in = N_DIV;
         end
         N_DIV: begin
            for (int i = 0; i < 3; i++) begin
               r_t = {drem_ff[i], dq_ff[i][16]};
               ge = (r_t >= {2'b00, div_ff});
               drem_in[i] = ge ? 33'(r_t - {2'b00, div_ff}) : r_t[32:0];
               dq_in[i] = {dq_ff[i][15:0], ge};
               qc[i] = (dq_in[i] > UnitQ) ? 16'(UnitQ) : 16'(dq_in[i]);
            end
            cnt_in = 5'(cnt_ff + 1'b1);
            if (cnt_ff == 5'd16) begin
               res_in.nx = neg_ff[0] ? -$signed(qc[0]) : $signed(qc[0]);
               res_in.ny = neg_ff[1] ? -$signed(qc[1]) : $signed(qc[1]);
               res_in.nz = neg_ff[2] ? -$signed(qc[2]) : $signed(qc[2]);
               res_in.degen = 1'b0;
               state_in = N_DONE;
            end
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      neg_ff <= neg_in;
      prod_ff <= prod_in;
      sq_ff <= sq_in;
      sqsh_ff <= sqsh_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      div_ff <= div_in;
      drem_ff <= drem_in;
      dq_ff <= dq_in;
      res_ff <= res_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == N_IDLE)
      else $error("normalizer started while busy");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      done && res.degen |-> res.nx == '0 && res.ny == '0 && res.nz == '0)
      else $error("degenerate result not zero");

   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      done && !res.degen |-> res.nx != '0 || res.ny != '0 || res.nz != '0)
      else $error("nondegenerate result is zero");

endmodule

>>> sv/mvna_back.sv
module mvna_back #(
   parameter int MAX_VERTICES = mvna_pkg::MaxVertices
) (
   input  logic clock,
   input  logic reset,
   input  mvna_pkg::item_type head,
   input  logic head_valid,
   output logic pop,
   output logic clearing,
   output mvna_pkg::rsp_type rsp,
   output logic rsp_valid,
   input  logic rsp_take
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int PW = 34;
   localparam int OPtrW = $clog2(mvna_pkg::OfDepth);
   localparam int OCntW = $clog2(mvna_pkg::OfDepth + 1);
   localparam int SumW = mvna_pkg::SumW;
   localparam int PosW = mvna_pkg::PosW;
   localparam int VecW = mvna_pkg::VecW;

   localparam logic [3:0] B_CLEAR = 4'd0;
   localparam logic [3:0] B_IDLE = 4'd1;
   localparam logic [3:0] B_LOAD = 4'd2;
   localparam logic [3:0] B_PA = 4'd3;
   localparam logic [3:0] B_PB = 4'd4;
   localparam logic [3:0] B_PC = 4'd5;
   localparam logic [3:0] B_DIFF = 4'd6;
   localparam logic [3:0] B_CROSS = 4'd7;
   localparam logic [3:0] B_QA = 4'd8;
   localparam logic [3:0] B_QV = 4'd9;
   localparam logic [3:0] B_NGO = 4'd10;
   localparam logic [3:0] B_NWAIT = 4'd11;
   localparam logic [3:0] B_ARD = 4'd12;
   localparam logic [3:0] B_AWR = 4'd13;
   localparam logic [3:0] B_OUT = 4'd14;

   function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] s,
                                               input logic [mvna_pkg::NormW-1:0] n);
      logic [SumW:0] t;
      t = {s[SumW-1], s} + (SumW+1)'($signed(n));
      if (t[SumW] != t[SumW-1]) begin
         return t[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end
      return t[SumW-1:0];
   endfunction

   logic [3:0] state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   mvna_pkg::item_type cur_ff, cur_in;
   logic [1:0] corner_ff, corner_in;
   logic [2:0] cnt_ff, cnt_in;
   logic signed [PosW-1:0] a_ff [3];
   logic signed [PosW-1:0] a_in [3];
   logic signed [PosW-1:0] b_ff [3];
   logic signed [PosW-1:0] b_in [3];
   logic signed [PosW:0] u_ff [3];
   logic signed [PosW:0] u_in [3];
   logic signed [PosW:0] w_ff [3];
   logic signed [PosW:0] w_in [3];
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [VecW-1:0] vec_ff [3];
   logic signed [VecW-1:0] vec_in [3];

   logic [3*PosW-1:0] pos_mem [MAX_VERTICES];
   logic [3*SumW-1:0] sum_mem [MAX_VERTICES];
   logic [3*PosW-1:0] pos_rd_ff;
   logic [3*SumW-1:0] sum_rd_ff;
   logic pos_we;
   logic [AW-1:0] pos_ra;
   logic sum_we;
   logic [AW-1:0] sum_wa;
   logic [AW-1:0] sum_ra;
   logic [3*SumW-1:0] sum_wd;
   logic [mvna_pkg::IdxW-1:0] corner_idx;
   logic signed [PosW-1:0] c_pos [3];

   logic signed [PosW:0] op_a, op_b;
   logic [2:0] pk;

   logic nstart;
   logic ndone;
   mvna_pkg::nres_type nres;

   mvna_pkg::rsp_type of_mem [mvna_pkg::OfDepth];
   mvna_pkg::rsp_type of_new;
   logic [OPtrW-1:0] of_wr_ff, of_wr_in;
   logic [OPtrW-1:0] of_rd_ff, of_rd_in;
   logic [OCntW-1:0] of_cnt_ff, of_cnt_in;
   logic of_full;
   logic of_push;
   logic of_pop;
   logic last_corner;

   mvna_norm u_norm (
      .clock(clock),
      .reset(reset),
      .start(nstart),
      .vx(vec_ff[0]),
      .vy(vec_ff[1]),
      .vz(vec_ff[2]),
      .done(ndone),
      .res(nres)
   );

   assign clearing = (state_ff == B_CLEAR);
   assign pop = (state_ff == B_IDLE) && head_valid;
   assign nstart = (state_ff == B_NGO);
   assign of_full = (of_cnt_ff == OCntW'(mvna_pkg::OfDepth));
   assign of_push = (state_ff == B_OUT) && !of_full;
   assign rsp_valid = (of_cnt_ff != '0);
   assign of_pop = rsp_take && rsp_valid;
   assign rsp = of_mem[of_rd_ff];
   assign last_corner = (corner_ff == (cur_ff.quad ? 2'd3 : 2'd2));

   assign c_pos[0] = $signed(pos_rd_ff[3*PosW-1:2*PosW]);
   assign c_pos[1] = $signed(pos_rd_ff[2*PosW-1:PosW]);
   assign c_pos[2] = $signed(pos_rd_ff[PosW-1:0]);

   always_comb begin
      case (corner_ff)
         2'd0: corner_idx = cur_ff.ka;
         2'd1: corner_idx = cur_ff.kb;
         2'd2: corner_idx = cur_ff.kc;
         default: corner_idx = cur_ff.kd;
      endcase
   end

   always_comb begin
      case (state_ff)
         B_PA: pos_ra = AW'(cur_ff.ka);
         B_PB: pos_ra = AW'(cur_ff.kb);
         default: pos_ra = AW'(cur_ff.kc);
      endcase
      sum_ra = (state_ff == B_QA) ? AW'(cur_ff.ka) : AW'(corner_idx);
      pos_we = (state_ff == B_LOAD);
      sum_we = (state_ff == B_CLEAR) || (state_ff == B_LOAD) || (state_ff == B_AWR);
      case (state_ff)
         B_CLEAR: sum_wa = clr_ff;
         B_LOAD: sum_wa = AW'(cur_ff.ka);
         default: sum_wa = AW'(corner_idx);
      endcase
      if (state_ff == B_AWR) begin
         sum_wd = {sat_add(sum_rd_ff[3*SumW-1:2*SumW], nres.nx),
                   sat_add(sum_rd_ff[2*SumW-1:SumW], nres.ny),
                   sat_add(sum_rd_ff[SumW-1:0], nres.nz)};
      end else begin
         sum_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[AW'(cur_ff.ka)] <= {cur_ff.pos_x, cur_ff.pos_y, cur_ff.pos_z};
      end
      pos_rd_ff <= pos_mem[pos_ra];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_wa] <= sum_wd;
      end
      sum_rd_ff <= sum_mem[sum_ra];
   end

   always_comb begin
      pk = 3'(cnt_ff - 1'b1);
      case (cnt_ff)
         3'd0: begin op_a = u_ff[1]; op_b = w_ff[2]; end
         3'd1: begin op_a = u_ff[2]; op_b = w_ff[1]; end
         3'd2: begin op_a = u_ff[2]; op_b = w_ff[0]; end
         3'd3: begin op_a = u_ff[0]; op_b = w_ff[2]; end
         3'd4: begin op_a = u_ff[0]; op_b = w_ff[1]; end
         default: begin op_a = u_ff[1]; op_b = w_ff[0]; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cur_in = cur_ff;
      corner_in = corner_ff;
      cnt_in = cnt_ff;
      a_in = a_ff;
      b_in = b_ff;
      u_in = u_ff;
      w_in = w_ff;
      prod_in = prod_ff;
      vec_in = vec_ff;
      case (state_ff)
         B_CLEAR: begin
            clr_in = AW'(clr_ff + 1'b1);
            if (clr_ff == AW'(MAX_VERTICES - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (head_valid) begin
               cur_in = head;
               case (head.cmd)
                  mvna_pkg::CmdLoad: state_in = B_LOAD;
                  mvna_pkg::CmdFace: state_in = B_PA;
                  mvna_pkg::CmdQuery: state_in = B_QA;
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_LOAD: state_in = B_IDLE;
         B_PA: state_in = B_PB;
         B_PB: begin
            a_in = c_pos;
            state_in = B_PC;
         end
         B_PC: begin
            b_in = c_pos;
            state_in = B_DIFF;
         end
         B_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               u_in[i] = (PosW+1)'(b_ff[i]) - (PosW+1)'(a_ff[i]);
               w_in[i] = (PosW+1)'(c_pos[i]) - (PosW+1)'(b_ff[i]);
               vec_in[i] = '0;
            end
            cnt_in = '0;
            state_in = B_CROSS;
         end
         B_CROSS: begin
            prod_in = PW'(op_a) * PW'(op_b);
            if (cnt_ff != '0) begin
               if (pk[0]) begin
                  vec_in[pk[2:1]] = vec_ff[pk[2:1]] - VecW'(prod_ff);
               end else begin
                  vec_in[pk[2:1]] = vec_ff[pk[2:1]] + VecW'(prod_ff);
               end
            end
            cnt_in = 3'(cnt_ff + 1'b1);
            if (cnt_ff == 3'd6) begin
               state_in = B_NGO;
            end
         end
         B_QA: state_in = B_QV;
         B_QV: begin
            vec_in[0] = VecW'($signed(sum_rd_ff[3*SumW-1:2*SumW]));
            vec_in[1] = VecW'($signed(sum_rd_ff[2*SumW-1:SumW]));
            vec_in[2] = VecW'($signed(sum_rd_ff[SumW-1:0]));
            state_in = B_NGO;
         end
         B_NGO: state_in = B_NWAIT;
         B_NWAIT: begin
            if (ndone) begin
               corner_in = '0;
               state_in = (cur_ff.cmd == mvna_pkg::CmdFace) ? B_ARD : B_OUT;
            end
         end
         B_ARD: state_in = B_AWR;
         B_AWR: begin
            if (last_corner) begin
               state_in = B_OUT;
            end else begin
               corner_in = 2'(corner_ff + 1'b1);
               state_in = B_ARD;
            end
         end
         B_OUT: begin
            if (!of_full) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      of_new.kind = (cur_ff.cmd == mvna_pkg::CmdQuery) ? mvna_pkg::KindVertex
                                                        : mvna_pkg::KindFace;
      of_new.item_index = cur_ff.idx_raw;
      of_new.nx = nres.nx;
      of_new.ny = nres.ny;
      of_new.nz = nres.nz;
      of_new.degen = nres.degen;
      of_new.bad = (cur_ff.cmd == mvna_pkg::CmdFace) && cur_ff.bad;
   end

   always_comb begin
      of_wr_in = of_wr_ff;
      of_rd_in = of_rd_ff;
      of_cnt_in = of_cnt_ff;
      if (of_push) begin
         of_wr_in = OPtrW'(of_wr_ff + 1'b1);
      end
      if (of_pop) begin
         of_rd_in = OPtrW'(of_rd_ff + 1'b1);
      end
      if (of_push && !of_pop) begin
         of_cnt_in = OCntW'(of_cnt_ff + 1'b1);
      end else if (of_pop && !of_push) begin
         of_cnt_in = OCntW'(of_cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (of_push) begin
         of_mem[of_wr_ff] <= of_new;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      corner_ff <= corner_in;
      cnt_ff <= cnt_in;
      a_ff <= a_in;
      b_ff <= b_in;
      u_ff <= u_in;
      w_ff <= w_in;
      prod_ff <= prod_in;
      vec_ff <= vec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff <= '0;
         of_wr_ff <= '0;
         of_rd_ff <= '0;
         of_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         of_wr_ff <= of_wr_in;
         of_rd_ff <= of_rd_in;
         of_cnt_ff <= of_cnt_in;
      end
   end

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !pop)
      else $error("item taken during clear pass");

   a_of_bound: assert property (@(posedge clock) disable iff (reset)
      of_cnt_ff <= OCntW'(mvna_pkg::OfDepth))
      else $error("result queue overflow");

   a_push_after_norm: assert property (@(posedge clock) disable iff (reset)
      of_push |-> cur_ff.cmd == mvna_pkg::CmdFace || cur_ff.cmd == mvna_pkg::CmdQuery)
      else $error("result for a command that has none");

endmodule

>>> sv/mesh_vertex_normal_accumulator.sv
// A face or query runs the iterative normalizer (shift search, 4-step square sum,
// 31-step square root, 17-step divide; a zero vector skips them), and a face then
// updates each corner's sum in a read state and a write state; a load writes the
// position and zeroes that vertex's sum. The back end handles one item at a time and
// pops no new one until the last is done; a 4-deep input and 2-deep result queue
// decouple. Synchronous reset; then a clear of every normal sum, req_full held high.
module mesh_vertex_normal_accumulator #(
   parameter int MAX_VERTICES = mvna_pkg::MaxVertices
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [1:0] req_cmd,
   input  logic [mvna_pkg::IdxW-1:0] req_index_a,
   input  logic [mvna_pkg::IdxW-1:0] req_index_b,
   input  logic [mvna_pkg::IdxW-1:0] req_index_c,
   input  logic [mvna_pkg::IdxW-1:0] req_index_d,
   input  logic [2:0] req_corner_count,
   input  logic signed [mvna_pkg::PosW-1:0] req_pos_x,
   input  logic signed [mvna_pkg::PosW-1:0] req_pos_y,
   input  logic signed [mvna_pkg::PosW-1:0] req_pos_z,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic rsp_kind,
   output logic [mvna_pkg::IdxW-1:0] rsp_item_index,
   output logic signed [mvna_pkg::NormW-1:0] rsp_norm_x,
   output logic signed [mvna_pkg::NormW-1:0] rsp_norm_y,
   output logic signed [mvna_pkg::NormW-1:0] rsp_norm_z,
   output logic rsp_degenerate,
   output logic rsp_bad_corner_count
);

   mvna_pkg::item_type head;
   mvna_pkg::rsp_type rsp;
   logic head_valid;
   logic pop;
   logic clearing;
   logic rsp_valid;

   mvna_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .clock(clock),
      .reset(reset),
      .hold(clearing),
      .req_push(req_push),
      .req_full(req_full),
      .req_cmd(req_cmd),
      .req_index_a(req_index_a),
      .req_index_b(req_index_b),
      .req_index_c(req_index_c),
      .req_index_d(req_index_d),
      .req_corner_count(req_corner_count),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .head(head),
      .head_valid(head_valid),
      .pop(pop)
   );

   mvna_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .head_valid(head_valid),
      .pop(pop),
      .clearing(clearing),
      .rsp(rsp),
      .rsp_valid(rsp_valid),
      .rsp_take(rsp_pop)
   );

   assign rsp_empty = !rsp_valid;
   assign rsp_kind = rsp.kind;
   assign rsp_item_index = rsp.item_index;
   assign rsp_norm_x = rsp.nx;
   assign rsp_norm_y = rsp.ny;
   assign rsp_norm_z = rsp.nz;
   assign rsp_degenerate = rsp.degen;
   assign rsp_bad_corner_count = rsp.bad;

endmodule
